/* rtl/bmhq_pkg.sv */
`timescale 1ns / 1ps
package bmhq_pkg;

  // Storage geometry
  localparam int CAPACITY  = 256;
  localparam int KEY_WIDTH = 32;
  localparam int CNT_W     = $clog2(CAPACITY + 1);

  // Fixed widths of the channel fields
  localparam int IO_KEY_W = 32;
  localparam int STATUS_W = 2;
  localparam int ENTRY_W  = 9;

  typedef logic signed [KEY_WIDTH-1:0] key_t;
  typedef logic [CNT_W-1:0]            cnt_t;

  typedef enum logic {
    MODE_INSERT = 1'b0,
    MODE_REMOVE = 1'b1
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_DONE  = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_t;

  // Operation broadcast to the cell row
  typedef struct packed {
    logic ins;
    logic rem;
  } cell_ctrl_t;

  // Convert a stored key to the channel width (zero fill or truncate)
  function automatic logic [IO_KEY_W-1:0] key_to_io(input key_t k);
    logic [63:0] wide;
    wide = 64'($unsigned(k));
    return wide[IO_KEY_W-1:0];
  endfunction

endpackage

/* rtl/bmhq_in_if.sv */
`timescale 1ns / 1ps
interface bmhq_in_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 mode;
  logic signed [bmhq_pkg::IO_KEY_W-1:0] key;

  modport source (output valid, output mode, output key, input ready);
  modport sink (input valid, input mode, input key, output ready);
endinterface

/* rtl/bmhq_out_if.sv */
`timescale 1ns / 1ps
interface bmhq_out_if;
  logic                                 valid;
  logic                                 ready;
  logic [bmhq_pkg::STATUS_W-1:0]        status;
  logic                                 top_valid;
  logic signed [bmhq_pkg::IO_KEY_W-1:0] top_key;
  logic signed [bmhq_pkg::IO_KEY_W-1:0] removed_key;
  logic [bmhq_pkg::ENTRY_W-1:0]         entry_count;

  modport source (output valid, output status, output top_valid, output top_key,
                  output removed_key, output entry_count, input ready);
  modport sink (input valid, input status, input top_valid, input top_key,
                input removed_key, input entry_count, output ready);
endinterface

/* rtl/bmhq_cell.sv */
`timescale 1ns / 1ps
// One slot of the sorted row; slot 0 holds the largest key.
module bmhq_cell (
  input  logic                 clk,
  input  bmhq_pkg::cell_ctrl_t ctrl,
  input  bmhq_pkg::key_t       new_key,
  input  logic                 slot_valid,
  input  bmhq_pkg::key_t       prev_key,
  input  logic                 prev_ge,
  input  bmhq_pkg::key_t       next_key,
  output bmhq_pkg::key_t       key_q,
  output bmhq_pkg::key_t       key_nxt,
  output logic                 ge
);
  import bmhq_pkg::*;

  key_t key_r;

  // Keep this slot when it holds a key not below the new one
  assign ge = slot_valid && (key_r >= new_key);

  // Insert: hold, take the new key, or take the neighbor's; remove: shift toward top
  always_comb begin
    key_nxt = key_r;
    if (ctrl.ins) begin
      if (ge) begin
        key_nxt = key_r;
      end else if (prev_ge) begin
        key_nxt = new_key;
      end else begin
        key_nxt = prev_key;
      end
    end else if (ctrl.rem) begin
      key_nxt = next_key;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

  assign key_q = key_r;
endmodule

/* rtl/bmhq_chain.sv */
`timescale 1ns / 1ps
// Row of CAPACITY cells kept in descending order.
module bmhq_chain (
  input  logic                 clk,
  input  bmhq_pkg::cell_ctrl_t ctrl,
  input  bmhq_pkg::key_t       new_key,
  input  bmhq_pkg::cnt_t       count,
  output bmhq_pkg::key_t       top_q,
  output bmhq_pkg::key_t       top_nxt
);
  import bmhq_pkg::*;

  key_t cell_key [CAPACITY];
  key_t cell_nxt [CAPACITY];
  logic cell_ge  [CAPACITY];

  // Wire each cell to its neighbors
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    key_t prev_key;
    logic prev_ge;
    key_t next_key;

    if (i == 0) begin : g_head
      assign prev_key = new_key;
      assign prev_ge  = 1'b1;
    end else begin : g_body
      assign prev_key = cell_key[i-1];
      assign prev_ge  = cell_ge[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign next_key = cell_key[i];
    end else begin : g_mid
      assign next_key = cell_key[i+1];
    end

    bmhq_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .new_key    (new_key),
      .slot_valid (CNT_W'(i) < count),
      .prev_key   (prev_key),
      .prev_ge    (prev_ge),
      .next_key   (next_key),
      .key_q      (cell_key[i]),
      .key_nxt    (cell_nxt[i]),
      .ge         (cell_ge[i])
    );
  end

  assign top_q   = cell_key[0];
  assign top_nxt = cell_nxt[0];
endmodule

/* rtl/binary_max_heap_queue_unit.sv */
`timescale 1ns / 1ps
// The result of an item is presented in the cycle after its transfer. Throughput:
// one item per cycle unless out_ch stalls; the cell row finishes an insert or
// remove in a single update, and the output register takes the next item in
// the cycle its waiting result transfers. Reset (rst_n low, synchronous) empties
// the queue and drops any pending result; key storage itself is not cleared.
module binary_max_heap_queue_unit (
  input  logic      clk,
  input  logic      rst_n,
  bmhq_in_if.sink   in_ch,
  bmhq_out_if.source out_ch
);
  import bmhq_pkg::*;

  cnt_t       count_r, count_nxt;
  logic       out_valid_r;
  status_t    status_r, status_nxt;
  logic       top_valid_r;
  logic [IO_KEY_W-1:0] top_key_r, top_key_nxt;
  logic [IO_KEY_W-1:0] removed_r, removed_nxt;
  cnt_t       entry_r;

  logic       accept;
  logic       full;
  logic       empty;
  cell_ctrl_t ctrl;
  key_t       new_key;
  key_t       top_q;
  key_t       top_nxt;

  // Take a new item whenever the output register is free or draining
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  assign full    = (count_r == cnt_t'(CAPACITY));
  assign empty   = (count_r == '0);
  assign new_key = key_t'(in_ch.key);

  // Decode the operation and next fill level
  always_comb begin
    ctrl        = '0;
    status_nxt  = STATUS_DONE;
    count_nxt   = count_r;
    removed_nxt = '0;
    if (accept) begin
      case (mode_t'(in_ch.mode))
        MODE_INSERT: begin
          if (full) begin
            status_nxt = STATUS_FULL;
          end else begin
            ctrl.ins  = 1'b1;
            count_nxt = count_r + cnt_t'(1);
          end
        end
        MODE_REMOVE: begin
          if (empty) begin
            status_nxt = STATUS_EMPTY;
          end else begin
            ctrl.rem    = 1'b1;
            count_nxt   = count_r - cnt_t'(1);
            removed_nxt = key_to_io(top_q);
          end
        end
        default: begin
          status_nxt = STATUS_DONE;
        end
      endcase
    end
    top_key_nxt = (count_nxt != '0) ? key_to_io(top_nxt) : '0;
  end

  bmhq_chain u_chain (
    .clk     (clk),
    .ctrl    (ctrl),
    .new_key (new_key),
    .count   (count_r),
    .top_q   (top_q),
    .top_nxt (top_nxt)
  );

  // Hold the fill level and the result handshake
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Load the result payload on each transfer
  always_ff @(posedge clk) begin
    if (accept) begin
      status_r    <= status_nxt;
      top_valid_r <= (count_nxt != '0);
      top_key_r   <= top_key_nxt;
      removed_r   <= removed_nxt;
      entry_r     <= count_nxt;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = status_r;
  assign out_ch.top_valid   = top_valid_r;
  assign out_ch.top_key     = top_key_r;
  assign out_ch.removed_key = removed_r;
  assign out_ch.entry_count = ENTRY_W'(entry_r);
endmodule
